// ===== src/rgsa_pkg.sv =====
// Shared types and constants for the gradient scatter-add table.
package rgsa_pkg;

    localparam int MAX_ROWS_DEF  = 1024;
    localparam int MAX_WIDTH_DEF = 256;

    localparam int ROW_IDX_W   = 10;
    localparam int COL_W       = 8;
    localparam int VAL_W       = 32;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;
    localparam int ROW_COUNT_W = 11;
    localparam int ROW_WIDTH_W = 9;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 11;

    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 11'd1024;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 9'd256;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 8'd1;

    // request codes; the unused code behaves as a read
    localparam logic [REQ_W-1:0] REQ_ACC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

    localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [ROW_IDX_W-1:0]    row_index;
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] grad_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] entry_value;
        logic [STAT_W-1:0]       status;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_CALC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic addr_load;
        logic rd_en;
        logic calc_load;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

// ===== src/row_gather_gradient_scatter_add.sv =====
// Top level of the gradient scatter-add table.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_stall  i_in_data (t_in_item)
//   out      output     o_out_valid/i_out_stall o_out_data (t_out_item)
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// On accept a request is captured; its address is loaded, the entry read
// (registered), the result computed and registered, then committed to
// the output register with the write-back of the entry for an accumulate or
// clear; only then is a new request taken. After reset a clearing pass
// zeroes every entry, input stalled; config writes are taken throughout.
// A stalled result holds in the output register and the sequencer waits.
module row_gather_gradient_scatter_add #(
    parameter int MAX_ROWS  = rgsa_pkg::MAX_ROWS_DEF,
    parameter int MAX_WIDTH = rgsa_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rgsa_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output rgsa_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rgsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgsa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rgsa_pkg::t_cmd cmd;
    rgsa_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    rgsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rgsa_dpath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/rgsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rgsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/rgsa_ctrl.sv =====
// Sequencer for the clearing pass and the read-modify-write of one request.
module rgsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rgsa_pkg::t_sts    i_sts,
    output rgsa_pkg::t_cmd    o_cmd
);

    rgsa_pkg::t_state r_state;
    rgsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgsa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            rgsa_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = rgsa_pkg::ST_IDLE;
                end
            end
            rgsa_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = rgsa_pkg::ST_ADDR;
                end
            end
            rgsa_pkg::ST_ADDR: begin
                o_cmd.addr_load = 1'b1;
                n_state         = rgsa_pkg::ST_READ;
            end
            rgsa_pkg::ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = rgsa_pkg::ST_CALC;
            end
            rgsa_pkg::ST_CALC: begin
                o_cmd.calc_load = 1'b1;
                n_state         = rgsa_pkg::ST_DONE;
            end
            rgsa_pkg::ST_DONE: begin
                // hold until the output register can take the beat
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = rgsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rgsa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rgsa_dpath.sv =====
// Datapath: config registers, range check, table memory, saturating add, output register.
module rgsa_dpath #(
    parameter int MAX_ROWS  = rgsa_pkg::MAX_ROWS_DEF,
    parameter int MAX_WIDTH = rgsa_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rgsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rgsa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  rgsa_pkg::t_in_item                 i_in_data,
    input  rgsa_pkg::t_cmd                     i_cmd,
    output rgsa_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output rgsa_pkg::t_out_item                o_out_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_WIDTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [rgsa_pkg::ROW_COUNT_W-1:0] r_row_count;
    logic [rgsa_pkg::ROW_WIDTH_W-1:0] r_row_width;
    rgsa_pkg::t_in_item               r_req;
    logic                             r_ok;
    logic [ADDR_W-1:0]                r_addr;
    logic [ADDR_W-1:0]                r_clr_addr;
    logic [rgsa_pkg::VAL_W-1:0]       r_res;
    logic [rgsa_pkg::STAT_W-1:0]      r_status;
    logic                             r_wr;
    logic                             r_out_valid;
    rgsa_pkg::t_out_item              r_out;

    logic                             in_range;
    logic [ADDR_W-1:0]                entry_addr;
    logic [rgsa_pkg::VAL_W-1:0]       rd_data;
    logic [rgsa_pkg::VAL_W:0]         sum;
    logic [rgsa_pkg::VAL_W-1:0]       n_res;
    logic [rgsa_pkg::STAT_W-1:0]      n_status;
    logic                             n_wr;
    logic                             ram_we;
    logic [ADDR_W-1:0]                ram_wr_addr;
    logic [rgsa_pkg::VAL_W-1:0]       ram_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= rgsa_pkg::ROW_COUNT_RST;
            r_row_width <= rgsa_pkg::ROW_WIDTH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == rgsa_pkg::CFG_ROW_COUNT) begin
                r_row_count <= i_cfg_data;
            end else if (i_cfg_index == rgsa_pkg::CFG_ROW_WIDTH) begin
                r_row_width <= i_cfg_data[rgsa_pkg::ROW_WIDTH_W-1:0];
            end
        end
    end

    // range check against both the live registers and the table size
    assign in_range = (rgsa_pkg::ROW_COUNT_W'(r_req.row_index) < r_row_count)
                   && (32'(r_req.row_index) < 32'(MAX_ROWS))
                   && (rgsa_pkg::ROW_WIDTH_W'(r_req.column) < r_row_width)
                   && (32'(r_req.column) < 32'(MAX_WIDTH));

    assign entry_addr = ADDR_W'(32'(r_req.row_index) * 32'(MAX_WIDTH)
                                + 32'(r_req.column));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_data;
        end
        if (i_cmd.addr_load) begin
            r_ok   <= in_range;
            r_addr <= in_range ? entry_addr : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    assign o_sts.clr_last = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign sum = {rd_data[rgsa_pkg::VAL_W-1], rd_data}
               + {r_req.grad_value[rgsa_pkg::VAL_W-1], r_req.grad_value};

    always_comb begin
        n_res    = rd_data;
        n_status = rgsa_pkg::STAT_OK;
        n_wr     = 1'b0;
        if (!r_ok) begin
            n_res    = '0;
            n_status = rgsa_pkg::STAT_RANGE;
        end else begin
            case (r_req.req_type)
                rgsa_pkg::REQ_ACC: begin
                    n_wr = 1'b1;
                    // extra sign bit differing from the sign bit means overflow: clamp
                    if (sum[rgsa_pkg::VAL_W] != sum[rgsa_pkg::VAL_W-1]) begin
                        n_res    = sum[rgsa_pkg::VAL_W] ? rgsa_pkg::SAT_MIN
                                                         : rgsa_pkg::SAT_MAX;
                        n_status = rgsa_pkg::STAT_SAT;
                    end else begin
                        n_res = sum[rgsa_pkg::VAL_W-1:0];
                    end
                end
                rgsa_pkg::REQ_CLEAR: begin
                    n_wr  = 1'b1;
                    n_res = '0;
                end
                rgsa_pkg::REQ_READ: begin
                    n_res = rd_data;
                end
                default: begin
                    n_res = rd_data;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_load) begin
            r_res    <= n_res;
            r_status <= n_status;
            r_wr     <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.entry_value <= r_res;
            r_out.status      <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign ram_we      = i_cmd.clr_step || (i_cmd.commit && r_wr);
    assign ram_wr_addr = i_cmd.clr_step ? r_clr_addr : r_addr;
    assign ram_wr_data = i_cmd.clr_step ? '0 : r_res;

    rgsa_ram #(
        .WIDTH (rgsa_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ===== src/rgsa_checker.sv =====
// Port-level checks for the gradient scatter-add table, with its bind.
module rgsa_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rgsa_pkg::t_out_item o_out_data
);

    // one request in flight: an accept closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a request is in flight");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == rgsa_pkg::STAT_RANGE)
        |-> (o_out_data.entry_value == '0))
        else $error("out-of-range result with nonzero value");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == rgsa_pkg::STAT_SAT)
        |-> (o_out_data.entry_value == rgsa_pkg::SAT_MAX
             || o_out_data.entry_value == rgsa_pkg::SAT_MIN))
        else $error("saturated result not at a range limit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("output beat changed while stalled");

endmodule

bind row_gather_gradient_scatter_add rgsa_checker u_rgsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
